// ----- hdl/matrix4_point_transform_divide_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the vertex transform engine
// Shared property wrappers used by the checker.
// ----------------------------------------------------------------------------
`ifndef MATRIX4_POINT_TRANSFORM_DIVIDE_DEFINES_SVH
`define MATRIX4_POINT_TRANSFORM_DIVIDE_DEFINES_SVH

// same-cycle implication, masked during reset
`define MTP_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked during reset
`define MTP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked through reset as well
`define MTP_ASSERT_ALWAYS_NEXT(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mtp_pkg.sv -----
// ----------------------------------------------------------------------------
// Vertex transform package
// Widths, codes and shared types of the 4x4 point transform pipeline.
// ----------------------------------------------------------------------------
package mtp_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int ACC_W      = PROD_W + 2;
  localparam int RES_W      = ACC_W - FRAC_BITS;
  localparam int NUM_W      = RES_W + FRAC_BITS;

  localparam logic [DATA_WIDTH-1:0] ONE_FX = DATA_WIDTH'(1) << FRAC_BITS;
  localparam logic [RES_W-1:0]      W_ONE  = RES_W'(1) << FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_POINT = 1'b1
  } func_t;

  typedef logic [15:0][DATA_WIDTH-1:0] matrix_t;

  // row dot products after the fraction shift, row 3 is w
  typedef struct packed {
    logic                  valid;
    logic [3:0][RES_W-1:0] row;
  } rows_t;

  typedef struct packed {
    logic       valid;
    logic       divided;
    logic [2:0] neg;
  } meta_t;

  typedef struct packed {
    meta_t                 meta;
    logic [2:0][NUM_W-1:0] mag;
  } quo_t;

  function automatic matrix_t identity_matrix();
    matrix_t m;
    for (int i = 0; i < 16; i++) begin
      m[i] = ((i % 5) == 0) ? ONE_FX : '0;
    end
    return m;
  endfunction

  localparam matrix_t MAT_RESET = identity_matrix();

endpackage

// ----- hdl/mtp_if.sv -----
// ----------------------------------------------------------------------------
// Vertex transform channels
// Valid/ready request channels for input items and result items.
// ----------------------------------------------------------------------------
interface mtp_in_if;
  import mtp_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [1:0]                   row_index;
  logic [1:0]                   col_index;
  logic signed [DATA_WIDTH-1:0] entry_value;
  logic signed [DATA_WIDTH-1:0] point_x;
  logic signed [DATA_WIDTH-1:0] point_y;
  logic signed [DATA_WIDTH-1:0] point_z;

  modport source (output valid, func, row_index, col_index, entry_value,
                  point_x, point_y, point_z, input ready);
  modport sink   (input valid, func, row_index, col_index, entry_value,
                  point_x, point_y, point_z, output ready);
endinterface

interface mtp_out_if;
  import mtp_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] out_x;
  logic signed [DATA_WIDTH-1:0] out_y;
  logic signed [DATA_WIDTH-1:0] out_z;
  logic                         divided;
  logic                         saturated;

  modport source (output valid, out_x, out_y, out_z, divided, saturated,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, divided, saturated,
                  output ready);
endinterface

// ----- hdl/mtp_mac.sv -----
// ----------------------------------------------------------------------------
// Matrix-vector multiply-accumulate
// Twelve products, two adder stages and the floor shift of each row sum.
// ----------------------------------------------------------------------------
module mtp_mac (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [mtp_pkg::DATA_WIDTH-1:0] x,
  input  logic signed [mtp_pkg::DATA_WIDTH-1:0] y,
  input  logic signed [mtp_pkg::DATA_WIDTH-1:0] z,
  input  mtp_pkg::matrix_t                  mat,
  output mtp_pkg::rows_t                    rows
);
  import mtp_pkg::*;

  logic                         p_valid;
  logic signed [PROD_W-1:0]     prod [4][3];
  logic signed [DATA_WIDTH-1:0] trans [4];

  logic                         s_valid;
  logic signed [ACC_W-1:0]      sum_a [4];
  logic signed [ACC_W-1:0]      sum_b [4];

  // stage 1: products
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        prod[r][0] <= $signed(mat[r*4+0]) * x;
        prod[r][1] <= $signed(mat[r*4+1]) * y;
        prod[r][2] <= $signed(mat[r*4+2]) * z;
        trans[r]   <= $signed(mat[r*4+3]);
      end
    end
  end

  // stage 2: pair sums, translation moved up to the product scale
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (en) begin
      s_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        sum_a[r] <= ACC_W'(prod[r][0]) + ACC_W'(prod[r][1]);
        sum_b[r] <= ACC_W'(prod[r][2]) + (ACC_W'(trans[r]) <<< FRAC_BITS);
      end
    end
  end

  // stage 3: final sum, drop fraction bits (floor)
  always_ff @(posedge clk) begin
    if (rst) begin
      rows.valid <= 1'b0;
    end else if (en) begin
      rows.valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [ACC_W-1:0] acc;
    if (en) begin
      for (int r = 0; r < 4; r++) begin
        acc         = sum_a[r] + sum_b[r];
        rows.row[r] <= acc[ACC_W-1:FRAC_BITS];
      end
    end
  end

endmodule

// ----- hdl/mtp_divider.sv -----
// ----------------------------------------------------------------------------
// Perspective divide pipeline
// Sign/magnitude setup, then one restoring quotient bit per stage, three lanes.
// ----------------------------------------------------------------------------
module mtp_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  mtp_pkg::rows_t rows,
  output mtp_pkg::quo_t  quo
);
  import mtp_pkg::*;

  meta_t                 meta [NUM_W+1];
  logic [RES_W-1:0]      dvs  [NUM_W+1];
  logic [2:0][RES_W-1:0] rem  [NUM_W+1];
  logic [2:0][NUM_W-1:0] num  [NUM_W+1];

  logic signed [RES_W-1:0] w;
  logic                    do_div;
  logic [RES_W-1:0]        w_mag;

  assign w      = $signed(rows.row[3]);
  assign do_div = (w != '0) && (w != $signed(W_ONE));
  assign w_mag  = w[RES_W-1] ? RES_W'(-w) : RES_W'(w);

  // setup: without a divide the value passes through as value / 1
  always_ff @(posedge clk) begin
    if (rst) begin
      meta[0].valid <= 1'b0;
    end else if (en) begin
      meta[0].valid <= rows.valid;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [NUM_W-1:0] n;
    if (en) begin
      meta[0].divided <= do_div;
      dvs[0]          <= do_div ? w_mag : RES_W'(1);
      for (int k = 0; k < 3; k++) begin
        n = do_div ? {rows.row[k], {FRAC_BITS{1'b0}}}
                   : {{FRAC_BITS{rows.row[k][RES_W-1]}}, rows.row[k]};
        meta[0].neg[k] <= n[NUM_W-1] ^ (do_div & w[RES_W-1]);
        num[0][k]      <= n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
        rem[0][k]      <= '0;
      end
    end
  end

  for (genvar s = 0; s < NUM_W; s++) begin : g_step
    logic [2:0][RES_W-1:0] rem_next;
    logic [2:0]            qbit;

    always_comb begin
      logic [RES_W:0] trial;
      logic [RES_W:0] diff;
      for (int k = 0; k < 3; k++) begin
        trial       = {rem[s][k], num[s][k][NUM_W-1]};
        diff        = trial - {1'b0, dvs[s]};
        qbit[k]     = (trial >= {1'b0, dvs[s]});
        rem_next[k] = qbit[k] ? diff[RES_W-1:0] : trial[RES_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        meta[s+1].valid <= 1'b0;
      end else if (en) begin
        meta[s+1].valid <= meta[s].valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        meta[s+1].divided <= meta[s].divided;
        meta[s+1].neg     <= meta[s].neg;
        dvs[s+1]          <= dvs[s];
        rem[s+1]          <= rem_next;
        for (int k = 0; k < 3; k++) begin
          num[s+1][k] <= {num[s][k][NUM_W-2:0], qbit[k]};
        end
      end
    end
  end

  assign quo.meta = meta[NUM_W];
  assign quo.mag  = num[NUM_W];

endmodule

// ----- hdl/matrix4_point_transform_divide.sv -----
// ----------------------------------------------------------------------------
// Vertex transform engine
// 4x4 homogeneous point transform with perspective divide and saturation.
// ----------------------------------------------------------------------------
// Point requests pass the multiply-accumulate stages, the divide pipeline,
//   the sign stage and the output register; the divide takes one bit per stage.
// Throughput: one item per cycle; a stalled result holds the whole pipeline.
// Matrix load requests take effect for the next accepted item, give no result.
// Reset (synchronous) empties the pipeline and loads the identity matrix.
module matrix4_point_transform_divide (
  input logic clk,
  input logic rst,
  mtp_in_if.sink    ingress,
  mtp_out_if.source egress
);
  import mtp_pkg::*;

  logic    en;
  logic    accept;
  matrix_t mat;
  rows_t   mac_rows;
  quo_t    div_quo;

  logic                  sg_valid;
  logic                  sg_div;
  logic [2:0][NUM_W:0]   sg_val;

  assign en            = !egress.valid || egress.ready;
  assign ingress.ready = en;
  assign accept        = ingress.valid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      mat <= MAT_RESET;
    end else if (accept && (ingress.func == FUNC_LOAD)) begin
      mat[{ingress.row_index, ingress.col_index}] <= ingress.entry_value;
    end
  end

  mtp_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (accept && (ingress.func == FUNC_POINT)),
    .x        (ingress.point_x),
    .y        (ingress.point_y),
    .z        (ingress.point_z),
    .mat      (mat),
    .rows     (mac_rows)
  );

  mtp_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .rows (mac_rows),
    .quo  (div_quo)
  );

  // apply sign to quotient magnitudes
  always_ff @(posedge clk) begin
    if (rst) begin
      sg_valid <= 1'b0;
    end else if (en) begin
      sg_valid <= div_quo.meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg_div <= div_quo.meta.divided;
      for (int k = 0; k < 3; k++) begin
        sg_val[k] <= div_quo.meta.neg[k] ? (NUM_W+1)'(-{1'b0, div_quo.mag[k]})
                                         : {1'b0, div_quo.mag[k]};
      end
    end
  end

  // clip to the output word
  logic [2:0][DATA_WIDTH-1:0] sat_val;
  logic [2:0]                 clip;

  always_comb begin
    logic [NUM_W-DATA_WIDTH+1:0] top;
    for (int k = 0; k < 3; k++) begin
      top        = sg_val[k][NUM_W:DATA_WIDTH-1];
      clip[k]    = !((&top) || !(|top));
      sat_val[k] = !clip[k] ? sg_val[k][DATA_WIDTH-1:0]
                            : (sg_val[k][NUM_W] ? SAT_MIN : SAT_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      egress.valid <= 1'b0;
    end else if (en) begin
      egress.valid <= sg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      egress.out_x     <= sat_val[0];
      egress.out_y     <= sat_val[1];
      egress.out_z     <= sat_val[2];
      egress.divided   <= sg_div;
      egress.saturated <= |clip;
    end
  end

endmodule

// ----- hdl/mtp_check.sv -----
// ----------------------------------------------------------------------------
// Vertex transform port checker
// Port-level properties of the transform engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "matrix4_point_transform_divide_defines.svh"

module mtp_check (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [mtp_pkg::DATA_WIDTH-1:0] out_x,
  input logic [mtp_pkg::DATA_WIDTH-1:0] out_y,
  input logic [mtp_pkg::DATA_WIDTH-1:0] out_z,
  input logic                           divided,
  input logic                           saturated
);
  import mtp_pkg::*;

  `MTP_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid, "result shown after reset")

  `MTP_ASSERT_NOW(a_stall_blocks_input, clk, rst, out_valid && !out_ready, !in_ready, "input taken while result stalled")

  `MTP_ASSERT_NEXT(a_stall_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(divided) && $stable(saturated), "stalled result changed")

  `MTP_ASSERT_NOW(a_sat_at_limit, clk, rst, out_valid && saturated, out_x == SAT_MAX || out_x == SAT_MIN || out_y == SAT_MAX || out_y == SAT_MIN || out_z == SAT_MAX || out_z == SAT_MIN, "saturated flag without a clipped value")

endmodule

bind matrix4_point_transform_divide mtp_check u_mtp_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (ingress.ready),
  .out_valid (egress.valid),
  .out_ready (egress.ready),
  .out_x     (egress.out_x),
  .out_y     (egress.out_y),
  .out_z     (egress.out_z),
  .divided   (egress.divided),
  .saturated (egress.saturated)
);

// ----- tb/matrix4_point_transform_divide_tb.sv -----
// ----------------------------------------------------------------------------
// Vertex transform engine testbench
// Streams matrix entry loads and point requests through the transform engine,
// predicts each point result in fixed point, and checks results in order.
// ----------------------------------------------------------------------------
module matrix4_point_transform_divide_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mtp_pkg::*;

  localparam int LATENCY  = NUM_W + 6;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 1300;

  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    logic  divided;
    logic  saturated;
  } point_result_t;

  class transform_scoreboard;
    word_t           coeff[16];
    point_result_t   pending[$];
    int              errors;
    int              n_points;
    int              n_loads;
    int              n_divided;
    int              n_saturated;

    function void reset_matrix();
      for (int i = 0; i < 16; i++) coeff[i] = ((i % 5) == 0) ? word_t'(ONE_FX) : '0;
      pending.delete();
      errors = 0;
    endfunction

    function wide_t row_dot(int r, word_t x, word_t y, word_t z);
      wide_t acc;
      acc = wide_t'(coeff[r*4]) * wide_t'(x) + wide_t'(coeff[r*4+1]) * wide_t'(y)
          + wide_t'(coeff[r*4+2]) * wide_t'(z) + (wide_t'(coeff[r*4+3]) <<< FRAC_BITS);
      return acc >>> FRAC_BITS;
    endfunction

    function word_t clip(wide_t v, ref logic sat);
      wide_t t;
      t = v >>> (DATA_WIDTH - 1);
      if (t == 0 || t == -1) return v[DATA_WIDTH-1:0];
      sat = 1'b1;
      return v < 0 ? word_t'(SAT_MIN) : word_t'(SAT_MAX);
    endfunction

    function void note_request(logic func, logic [1:0] r, logic [1:0] c, word_t ev,
                               word_t x, word_t y, word_t z);
      wide_t         res[3];
      wide_t         w;
      point_result_t p;
      logic          sat;
      if (func == FUNC_LOAD) begin
        coeff[r*4 + c] = ev;
        n_loads++;
        return;
      end
      for (int k = 0; k < 3; k++) res[k] = row_dot(k, x, y, z);
      w = row_dot(3, x, y, z);
      p.divided = (w != 0) && (w != (wide_t'(1) <<< FRAC_BITS));
      if (p.divided)
        for (int k = 0; k < 3; k++) res[k] = (res[k] <<< FRAC_BITS) / w;
      sat = 1'b0;
      p.x = clip(res[0], sat);
      p.y = clip(res[1], sat);
      p.z = clip(res[2], sat);
      p.saturated = sat;
      n_points++;
      if (p.divided) n_divided++;
      if (p.saturated) n_saturated++;
      pending.push_back(p);
    endfunction

    function void check_result(point_result_t got);
      point_result_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result x=%h y=%h z=%h", got.x, got.y, got.z);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.x !== exp.x) begin
        $error("out_x expected %h actual %h", exp.x, got.x); errors++;
      end
      if (got.y !== exp.y) begin
        $error("out_y expected %h actual %h", exp.y, got.y); errors++;
      end
      if (got.z !== exp.z) begin
        $error("out_z expected %h actual %h", exp.z, got.z); errors++;
      end
      if (got.divided !== exp.divided) begin
        $error("divided expected %b actual %b", exp.divided, got.divided); errors++;
      end
      if (got.saturated !== exp.saturated) begin
        $error("saturated expected %b actual %b", exp.saturated, got.saturated); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  mtp_in_if  ingress();
  mtp_out_if egress();

  matrix4_point_transform_divide DUT (
    .clk(clk), .rst(rst), .ingress(ingress.sink), .egress(egress.source)
  );

  transform_scoreboard sb = new();
  int  idle_cycles = 0;
  bit  hold_off = 0;

  initial begin
    ingress.valid = 1'b0;
    ingress.func = FUNC_LOAD;
    ingress.row_index = '0;
    ingress.col_index = '0;
    ingress.entry_value = '0;
    ingress.point_x = '0;
    ingress.point_y = '0;
    ingress.point_z = '0;
    egress.ready = 1'b0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0: return word_t'(SAT_MAX);
      1: return word_t'(SAT_MIN);
      2: return '0;
      3: return word_t'(ONE_FX);
      4, 5: return word_t'($urandom_range(0, 32'h3_ffff)) - word_t'(32'h2_0000);
      default: return word_t'($urandom());
    endcase
  endfunction

  task automatic send_request(logic func, logic [1:0] r, logic [1:0] c, word_t ev,
                              word_t x, word_t y, word_t z);
    int g;
    g = gap_len();
    if (g > 0) begin
      ingress.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    ingress.valid <= 1'b1;
    ingress.func <= func;
    ingress.row_index <= r;
    ingress.col_index <= c;
    ingress.entry_value <= ev;
    ingress.point_x <= x;
    ingress.point_y <= y;
    ingress.point_z <= z;
    do @(posedge clk); while (!ingress.ready);
    sb.note_request(func, r, c, ev, x, y, z);
  endtask

  task automatic load_entry(int r, int c, word_t v);
    send_request(FUNC_LOAD, r[1:0], c[1:0], v, word_t'($urandom()), word_t'($urandom()),
                 word_t'($urandom()));
  endtask

  task automatic send_point(word_t x, word_t y, word_t z);
    send_request(FUNC_POINT, 2'($urandom()), 2'($urandom()), word_t'($urandom()), x, y, z);
  endtask

  // sink side: random stalls, plus one long hold-off on request
  initial begin
    point_result_t got;
    int g;
    forever begin
      @(posedge clk);
      if (egress.valid && egress.ready) begin
        got.x = egress.out_x;
        got.y = egress.out_y;
        got.z = egress.out_z;
        got.divided = egress.divided;
        got.saturated = egress.saturated;
        sb.check_result(got);
      end
      if (rst) continue;
      if (hold_off) begin
        egress.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 0;
        egress.ready <= 1'b1;
      end else begin
        g = gap_len();
        egress.ready <= (g == 0);
      end
    end
  end

  // watchdog on cycles without any accepted request or result
  initial begin
    forever begin
      @(posedge clk);
      if ((ingress.valid && ingress.ready) || (egress.valid && egress.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("matrix4_point_transform_divide_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    word_t x, y, z;
    sb.reset_matrix();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity matrix, field extremes
    send_point(word_t'(SAT_MAX), word_t'(SAT_MIN), '0);
    send_point(word_t'(32'h0001_8000), word_t'(-32'sh2_0000), word_t'(32'hffff_ffff));
    // w = 0: zero the last row
    load_entry(3, 3, '0);
    send_point(word_t'(32'h0003_0000), word_t'(32'h0001_0000), word_t'(SAT_MIN));
    // w = 2.0 divides, w negative and tiny
    load_entry(3, 3, word_t'(32'h0002_0000));
    send_point(word_t'(32'h0005_0000), word_t'(-32'sh3_0000), word_t'(32'h0000_0001));
    load_entry(3, 2, word_t'(SAT_MIN));
    load_entry(3, 3, '0);
    send_point(word_t'(32'h0000_0001), word_t'(32'h0000_0001), word_t'(32'h0000_0001));
    // large coefficients for saturation, translation extremes
    load_entry(0, 0, word_t'(SAT_MAX));
    load_entry(1, 3, word_t'(SAT_MIN));
    load_entry(2, 3, word_t'(SAT_MAX));
    load_entry(3, 2, '0);
    load_entry(3, 3, word_t'(ONE_FX));
    send_point(word_t'(SAT_MAX), word_t'(SAT_MAX), word_t'(SAT_MAX));
    send_point(word_t'(SAT_MIN), '0, '0);
    load_entry(3, 0, word_t'(32'h0000_0100));
    send_point(word_t'(SAT_MIN), word_t'(SAT_MIN), word_t'(SAT_MAX));

    // sender keeps offering while the sink holds off
    hold_off = 1;
    for (int i = 0; i < 200; i++) begin
      x = rand_word(); y = rand_word(); z = rand_word();
      ingress.valid <= 1'b1;
      ingress.func <= FUNC_POINT;
      ingress.point_x <= x;
      ingress.point_y <= y;
      ingress.point_z <= z;
      do @(posedge clk); while (!ingress.ready);
      sb.note_request(FUNC_POINT, 2'b00, 2'b00, ingress.entry_value, x, y, z);
    end

    // random loads and points, mostly points
    for (int i = 0; i < N_RANDOM; i++) begin
      if ($urandom_range(0, 99) < 20)
        load_entry($urandom_range(0, 3), $urandom_range(0, 3), rand_word());
      else if ($urandom_range(0, 9) == 0)
        send_point(word_t'($urandom()), word_t'($urandom()), word_t'($urandom()));
      else
        send_point(rand_word(), rand_word(), rand_word());
    end
    ingress.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d points (%0d divided, %0d saturated) and %0d matrix loads",
             sb.n_points, sb.n_divided, sb.n_saturated, sb.n_loads);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("matrix4_point_transform_divide_tb: clean");
    else
      $display("matrix4_point_transform_divide_tb: errors");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/mtp_pkg.sv
hdl/mtp_if.sv
hdl/mtp_mac.sv
hdl/mtp_divider.sv
hdl/matrix4_point_transform_divide.sv
hdl/mtp_check.sv
tb/matrix4_point_transform_divide_tb.sv
